>>> src/tspg_pkg.sv
// package for the trapezoid step pulse generator
// item structs, field widths, config register indexes and defaults; no dependencies
package tspg_pkg;

    localparam int SPEED_W  = 20;
    localparam int CNT_W    = 32;
    localparam int OPND_W   = SPEED_W + 1;
    localparam int PROD_W   = OPND_W + SPEED_W;
    localparam int CFG_IDX_W = 2;

    localparam int TICKS_PER_HALF_SECOND = 500000;

    localparam logic [CFG_IDX_W-1:0] REG_START_SPEED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_STEP  = 2'd2;

    localparam logic [SPEED_W-1:0] START_SPEED_RST = 20'd100;
    localparam logic [SPEED_W-1:0] MAX_SPEED_RST   = 20'd1000;
    localparam logic [SPEED_W-1:0] ACCEL_STEP_RST  = 20'd10;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    typedef struct packed {
        logic             action;
        logic [CNT_W-1:0] step_count;
        logic             direction;
        logic [CNT_W-1:0] ramp_up_steps;
        logic [CNT_W-1:0] cruise_steps;
        logic             watch_stall;
        logic [CNT_W-1:0] stall_threshold;
        logic [CNT_W-1:0] warmup_count;
        logic             diag_level;
    } cmd_t;

    typedef struct packed {
        logic             step_out;
        logic             dir_out;
        logic             busy_res;
        logic             done_res;
        logic [CNT_W-1:0] steps_walked;
        logic             stalled;
    } res_t;

    typedef enum logic [1:0] {
        MODE_RAMP   = 2'd0,
        MODE_CRUISE = 2'd1,
        MODE_DECEL  = 2'd2
    } mode_t;

    // saturate a step multiplier operand; anything this large overshoots any speed
    function automatic logic [OPND_W-1:0] sat_opnd(input logic [CNT_W:0] x);
        logic [OPND_W-1:0] r;
        if (x[CNT_W:OPND_W] != '0)
            r = '1;
        else
            r = x[OPND_W-1:0];
        return r;
    endfunction

endpackage

>>> src/tspg_div.sv
// restoring divider: half period = ticks per half second / speed, one quotient bit per cycle
// depends on tspg_pkg
module tspg_div #(
    parameter int TICKS_PER_HALF_SECOND = tspg_pkg::TICKS_PER_HALF_SECOND
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      start,
    input  logic [tspg_pkg::SPEED_W-1:0]              divisor,
    output logic                                      done,
    output logic [$clog2(TICKS_PER_HALF_SECOND+1)-1:0] quotient
);
    localparam int HP_W = $clog2(TICKS_PER_HALF_SECOND + 1);
    localparam int CW   = $clog2(HP_W + 1);
    localparam int SW   = tspg_pkg::SPEED_W;
    localparam logic [HP_W-1:0] DIVIDEND = HP_W'(TICKS_PER_HALF_SECOND);

    // the partial remainder stays below the divisor
    logic [SW-1:0]   rem_reg;
    logic [HP_W-1:0] quo_reg;
    logic [SW-1:0] div_reg;
    logic [CW-1:0] cnt_reg;
    logic          run_reg;
    logic          done_reg;
    logic          zero_reg;

    logic [SW:0] trial;
    logic        fits;

    assign trial = {rem_reg, quo_reg[HP_W-1]};
    assign fits  = trial >= {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            quo_reg  <= '0;
            div_reg  <= '0;
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            zero_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                rem_reg  <= '0;
                quo_reg  <= DIVIDEND;
                div_reg  <= divisor;
                cnt_reg  <= CW'(HP_W);
                zero_reg <= (divisor == '0);
                // zero speed takes the dividend as is
                run_reg  <= (divisor != '0);
                done_reg <= (divisor == '0);
            end
            else if (run_reg)
            begin
                rem_reg <= fits ? SW'(trial - {1'b0, div_reg}) : trial[SW-1:0];
                quo_reg <= {quo_reg[HP_W-2:0], fits};
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;

    always_comb
    begin
        if (zero_reg)
            quotient = DIVIDEND;
        else if (quo_reg == '0)
            quotient = HP_W'(1);
        else
            quotient = quo_reg;
    end

endmodule

>>> src/trapezoid_step_pulse_generator_top.sv
// top level of the trapezoid step pulse generator: move state, speed sequencer, item ports
// depends on tspg_pkg and tspg_div
//
// channel   direction  handshake           payload
// cmd       in         cmd_valid/cmd_stall cmd (start or one-microsecond tick item)
// res       out        res_valid/res_stall res (pin levels and move status)
// cfg       in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// an idle tick, a zero count start and a tick that begins no new step are handled in S_IDLE;
// a start item or a tick that begins a step runs the sequencer through S_CLASS, S_PEAK
// (deceleration only), S_MUL (ramp and deceleration) and S_SPEED, and then waits on the
// divider, using the shared multiplier and the bit-serial divider; a zero speed skips the divider
// reset clears the move state and loads the register defaults; no clearing pass
// cmd_stall is high while a step is being set up or a waiting result is stalled
module trapezoid_step_pulse_generator_top #(
    parameter int TICKS_PER_HALF_SECOND = tspg_pkg::TICKS_PER_HALF_SECOND
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_stall,
    input  tspg_pkg::cmd_t                cmd,
    output logic                          res_valid,
    input  logic                          res_stall,
    output tspg_pkg::res_t                res,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tspg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tspg_pkg::SPEED_W-1:0]  cfg_data
);
    localparam int HP_W = $clog2(TICKS_PER_HALF_SECOND + 1);
    localparam int SW   = tspg_pkg::SPEED_W;
    localparam int CW   = tspg_pkg::CNT_W;
    localparam int OW   = tspg_pkg::OPND_W;
    localparam int PW   = tspg_pkg::PROD_W;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CLASS = 5'b00010,
        S_PEAK  = 5'b00100,
        S_MUL   = 5'b01000,
        S_SPEED = 5'b10000
    } seq_t;
    // the divider wait is S_SPEED followed by div_busy
    seq_t state_reg;
    logic div_busy_reg;

    logic [SW-1:0] start_speed_reg, max_speed_reg, accel_step_reg;

    logic          moving_reg;
    logic [CW-1:0] step_index_reg, total_steps_reg, ramp_count_reg, cruise_count_reg;
    logic [SW-1:0] current_speed_reg;
    logic [HP_W-1:0] half_period_reg, phase_ticks_reg;
    logic          pin_high_reg, dir_level_reg, watching_reg, prev_diag_reg;
    logic [CW-1:0] edge_limit_reg, warmup_limit_reg, edge_count_reg;

    tspg_pkg::mode_t mode_reg;
    logic [OW-1:0] opnd_reg;
    logic [PW-1:0] prod_reg;
    logic [SW-1:0] peak_reg;

    tspg_pkg::res_t res_reg;
    tspg_pkg::res_t res_next;
    logic           res_valid_reg;

    logic cmd_fire;
    assign cmd_stall = (state_reg != S_IDLE) || div_busy_reg || (res_valid_reg && res_stall);
    assign cmd_fire  = cmd_valid && !cmd_stall;
    assign cfg_ready = 1'b1;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // shared multiplier
    logic [OW-1:0] mul_a;
    logic [PW-1:0] mul_p;
    assign mul_a = (state_reg == S_PEAK) ? tspg_pkg::sat_opnd({1'b0, ramp_count_reg}) : opnd_reg;
    assign mul_p = {{(PW-OW){1'b0}}, mul_a} * {{(PW-SW){1'b0}}, accel_step_reg};

    // clamp start plus product to max
    logic [PW:0]   ramp_sum;
    logic [SW-1:0] ramp_v;
    assign ramp_sum = {1'b0, prod_reg} + (PW+1)'(start_speed_reg);
    assign ramp_v   = (ramp_sum > (PW+1)'(max_speed_reg)) ? max_speed_reg : ramp_sum[SW-1:0];

    logic [SW-1:0] decel_v, speed_v;
    always_comb
    begin
        if (PW'(peak_reg) > prod_reg)
            decel_v = peak_reg - prod_reg[SW-1:0];
        else
            decel_v = start_speed_reg;
        if (decel_v < start_speed_reg)
            decel_v = start_speed_reg;
        case (mode_reg)
            tspg_pkg::MODE_RAMP:  speed_v = ramp_v;
            tspg_pkg::MODE_DECEL: speed_v = decel_v;
            default:              speed_v = current_speed_reg;
        endcase
    end

    // step classification
    logic [CW:0] cruise_end, idx_plus, dec_plus;
    assign cruise_end = {1'b0, ramp_count_reg} + {1'b0, cruise_count_reg};
    assign idx_plus   = {1'b0, step_index_reg} + (CW+1)'(1);
    assign dec_plus   = {1'b0, step_index_reg} - cruise_end + (CW+1)'(1);

    logic            div_start, div_done;
    logic [HP_W-1:0] div_q;
    assign div_start = (state_reg == S_SPEED);

    tspg_div #(
        .TICKS_PER_HALF_SECOND(TICKS_PER_HALF_SECOND)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .divisor  (speed_v),
        .done     (div_done),
        .quotient (div_q)
    );

    // tick evaluation
    logic [HP_W:0]  phase_inc;
    logic           phase_more;
    logic [CW-1:0]  walked;
    logic           edge_hit;
    logic [CW-1:0]  edge_cnt_inc;
    logic           stall_end;
    assign phase_inc    = {1'b0, phase_ticks_reg} + (HP_W+1)'(1);
    assign phase_more   = phase_inc < {1'b0, half_period_reg};
    assign walked       = step_index_reg + CW'(1);
    assign edge_hit     = watching_reg && cmd.diag_level && !prev_diag_reg &&
                          (step_index_reg >= warmup_limit_reg);
    assign edge_cnt_inc = (edge_count_reg == '1) ? edge_count_reg : edge_count_reg + CW'(1);
    assign stall_end    = edge_hit && (edge_cnt_inc >= edge_limit_reg);

    // result for the item on the cmd port
    always_comb
    begin
        res_next          = '0;
        res_next.dir_out  = dir_level_reg;
        res_next.busy_res = moving_reg;
        if (cmd.action == tspg_pkg::ACT_START)
        begin
            if (cmd.step_count == '0)
            begin
                res_next.busy_res = 1'b0;
                res_next.done_res = 1'b1;
            end
            else
            begin
                res_next.dir_out  = cmd.direction;
                res_next.busy_res = 1'b1;
            end
        end
        else if (moving_reg)
        begin
            res_next.step_out = pin_high_reg;
            if (!phase_more && !pin_high_reg && (stall_end || walked == total_steps_reg))
            begin
                res_next.busy_res     = 1'b0;
                res_next.done_res     = 1'b1;
                res_next.steps_walked = walked;
                res_next.stalled      = stall_end;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_speed_reg   <= tspg_pkg::START_SPEED_RST;
            max_speed_reg     <= tspg_pkg::MAX_SPEED_RST;
            accel_step_reg    <= tspg_pkg::ACCEL_STEP_RST;
            state_reg         <= S_IDLE;
            div_busy_reg      <= 1'b0;
            moving_reg        <= 1'b0;
            step_index_reg    <= '0;
            total_steps_reg   <= '0;
            ramp_count_reg    <= '0;
            cruise_count_reg  <= '0;
            current_speed_reg <= '0;
            half_period_reg   <= '0;
            phase_ticks_reg   <= '0;
            pin_high_reg      <= 1'b0;
            dir_level_reg     <= 1'b0;
            watching_reg      <= 1'b0;
            edge_limit_reg    <= '0;
            warmup_limit_reg  <= '0;
            edge_count_reg    <= '0;
            prev_diag_reg     <= 1'b0;
            mode_reg          <= tspg_pkg::MODE_CRUISE;
            opnd_reg          <= '0;
            prod_reg          <= '0;
            peak_reg          <= '0;
            res_reg           <= '0;
            res_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    tspg_pkg::REG_START_SPEED: start_speed_reg <= cfg_data;
                    tspg_pkg::REG_MAX_SPEED:   max_speed_reg   <= cfg_data;
                    tspg_pkg::REG_ACCEL_STEP:  accel_step_reg  <= cfg_data;
                    default: ;
                endcase
            end

            res_valid_reg <= cmd_fire || (res_valid_reg && res_stall);

            case (state_reg)
                S_IDLE:
                begin
                    if (cmd_fire)
                    begin
                        res_reg <= res_next;
                        if (cmd.action == tspg_pkg::ACT_START)
                        begin
                            if (cmd.step_count == '0)
                            begin
                                moving_reg   <= 1'b0;
                                pin_high_reg <= 1'b0;
                            end
                            else
                            begin
                                moving_reg        <= 1'b1;
                                dir_level_reg     <= cmd.direction;
                                total_steps_reg   <= cmd.step_count;
                                ramp_count_reg    <= cmd.ramp_up_steps;
                                cruise_count_reg  <= cmd.cruise_steps;
                                watching_reg      <= cmd.watch_stall;
                                edge_limit_reg    <= cmd.stall_threshold;
                                warmup_limit_reg  <= cmd.warmup_count;
                                edge_count_reg    <= '0;
                                prev_diag_reg     <= 1'b0;
                                step_index_reg    <= '0;
                                current_speed_reg <= start_speed_reg;
                                pin_high_reg      <= 1'b1;
                                phase_ticks_reg   <= '0;
                                state_reg         <= S_CLASS;
                            end
                        end
                        else if (moving_reg)
                        begin
                            if (phase_more)
                                phase_ticks_reg <= phase_inc[HP_W-1:0];
                            else if (pin_high_reg)
                            begin
                                pin_high_reg    <= 1'b0;
                                phase_ticks_reg <= '0;
                            end
                            else
                            begin
                                // last tick of the step: sample diag, then end or go on
                                if (watching_reg)
                                    prev_diag_reg <= cmd.diag_level;
                                if (edge_hit)
                                    edge_count_reg <= edge_cnt_inc;
                                if (stall_end || walked == total_steps_reg)
                                begin
                                    moving_reg      <= 1'b0;
                                    pin_high_reg    <= 1'b0;
                                    phase_ticks_reg <= '0;
                                end
                                else
                                begin
                                    step_index_reg  <= walked;
                                    pin_high_reg    <= 1'b1;
                                    phase_ticks_reg <= '0;
                                    state_reg       <= S_CLASS;
                                end
                            end
                        end
                    end
                    if (div_done)
                    begin
                        div_busy_reg    <= 1'b0;
                        half_period_reg <= div_q;
                    end
                end
                S_CLASS:
                begin
                    if ({1'b0, step_index_reg} < {1'b0, ramp_count_reg})
                    begin
                        mode_reg  <= tspg_pkg::MODE_RAMP;
                        opnd_reg  <= tspg_pkg::sat_opnd(idx_plus);
                        state_reg <= S_MUL;
                    end
                    else if ({1'b0, step_index_reg} >= cruise_end)
                    begin
                        mode_reg  <= tspg_pkg::MODE_DECEL;
                        opnd_reg  <= tspg_pkg::sat_opnd(dec_plus);
                        state_reg <= S_PEAK;
                    end
                    else
                    begin
                        mode_reg  <= tspg_pkg::MODE_CRUISE;
                        state_reg <= S_SPEED;
                    end
                end
                S_PEAK:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    // peak from the ramp product, then the step product
                    peak_reg  <= ramp_v;
                    prod_reg  <= mul_p;
                    state_reg <= S_SPEED;
                end
                S_SPEED:
                begin
                    current_speed_reg <= speed_v;
                    div_busy_reg      <= 1'b1;
                    state_reg         <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
